/* rtl/core/mfq_pkg.sv */
// Package for the multilevel feedback queue scheduler.
// Field widths, codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package mfq_pkg;

    localparam int NUM_LEVELS_DEF  = 6;
    localparam int MAX_ENTRIES_DEF = 64;

    localparam int TID_W      = 16;
    localparam int LVL_PORT_W = 3;
    localparam int OUTCOME_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int EVT_W      = 10;

    localparam logic [EVT_W-1:0] BOOST_INTERVAL_RST = EVT_W'(100);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SCHED  = 1'b1
    } t_opcode;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_PREEMPT  = 2'd0,
        OUT_FINISHED = 2'd1,
        OUT_BLOCKED  = 2'd2
    } t_outcome;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic ld_ins;    // latch an insert operand
        logic ld_req;    // latch the running thread for requeue
        logic alloc;     // take an entry and link it at the tail
        logic pop;       // settle the free list head
        logic count;     // count the event, arm the boost sweep
        logic boost;     // splice one level in front of level 0
        logic pick;      // find the lowest nonempty level, read its head
        logic deq;       // unlink the head, free it, report it
        logic res_full;
        logic res_ok;
        logic res_none;
    } t_mfq_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic req_needed;
        logic boost_hit;
        logic boost_last;
        logic pick_none;
    } t_mfq_stat;

endpackage

/* rtl/core/mfq_ctrl.sv */
// Controller state machine of the multilevel feedback queue scheduler.
// Sequences allocate, count, boost, pick and dequeue steps. Depends on mfq_pkg.
`timescale 1ns / 1ps

module mfq_ctrl import mfq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      i_opcode,
    input  t_mfq_stat i_stat,
    output t_mfq_cmd  o_cmd,
    output logic      busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ALLOC = 7'b0000010,
        S_POP   = 7'b0000100,
        S_COUNT = 7'b0001000,
        S_BOOST = 7'b0010000,
        S_PICK  = 7'b0100000,
        S_DEQ   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_sched, n_is_sched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_is_sched <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_sched <= n_is_sched;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_sched = r_is_sched;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_INSERT) begin
                        o_cmd.ld_ins = 1'b1;
                        n_is_sched   = 1'b0;
                        n_state      = S_ALLOC;
                    end else if (i_stat.req_needed) begin
                        o_cmd.ld_req = 1'b1;
                        n_is_sched   = 1'b1;
                        n_state      = S_ALLOC;
                    end else begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                if (i_stat.full) begin
                    // refused: nothing has changed yet
                    o_cmd.res_full = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                if (r_is_sched) begin
                    n_state = S_COUNT;
                end else begin
                    o_cmd.res_ok = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = i_stat.boost_hit ? S_BOOST : S_PICK;
            end
            S_BOOST: begin
                o_cmd.boost = 1'b1;
                if (i_stat.boost_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                if (i_stat.pick_none) begin
                    o_cmd.res_none = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DEQ;
                end
            end
            S_DEQ: begin
                o_cmd.deq = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* rtl/core/mfq_dp.sv */
// Datapath of the multilevel feedback queue scheduler: entry store memories,
// level head/tail registers, free list, event counter and result registers.
// Depends on mfq_pkg; driven by mfq_ctrl commands.
`timescale 1ns / 1ps

module mfq_dp import mfq_pkg::*; #(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mfq_cmd              i_cmd,
    output t_mfq_stat             o_stat,
    input  logic [TID_W-1:0]      i_thread_id,
    input  logic [LVL_PORT_W-1:0] i_insert_level,
    input  logic [OUTCOME_W-1:0]  i_current_outcome,
    input  logic                  i_cfg_wr_en,
    input  logic [EVT_W-1:0]      i_cfg_wr_data,
    output logic                  o_strobe,
    output logic [STATUS_W-1:0]   o_status,
    output logic [TID_W-1:0]      o_selected_id,
    output logic [LVL_PORT_W-1:0] o_selected_level
);

    localparam int LVL_W = $clog2(NUM_LEVELS);
    localparam int ENT_W = $clog2(MAX_ENTRIES);
    localparam int LNK_W = $clog2(MAX_ENTRIES + 1);
    localparam int PAY_W = TID_W + LVL_W;

    localparam logic [LNK_W-1:0] NIL      = LNK_W'(MAX_ENTRIES);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);
    localparam logic [15:0]      LVL_LAST_EXT = 16'(NUM_LEVELS - 1);

    // entry store
    logic [LNK_W-1:0] mem_next [MAX_ENTRIES];
    logic [PAY_W-1:0] mem_pay  [MAX_ENTRIES];

    logic [LNK_W-1:0] r_head [NUM_LEVELS];
    logic [LNK_W-1:0] r_tail [NUM_LEVELS];
    logic [LNK_W-1:0] r_free_head;   // recycled entries
    logic [LNK_W-1:0] r_fresh;       // entries never used lie at and above this
    logic [EVT_W-1:0] r_evt;
    logic [EVT_W-1:0] r_interval;
    logic [TID_W-1:0] r_run_tid;
    logic [LVL_W-1:0] r_run_lvl;
    logic             r_run_valid;

    logic [TID_W-1:0] r_op_tid;
    logic [LVL_W-1:0] r_lvl;
    logic [ENT_W-1:0] r_ent;
    logic             r_recycled;
    logic [LNK_W-1:0] r_rd_next;
    logic [PAY_W-1:0] r_rd_pay;

    logic                  r_strobe;
    logic [STATUS_W-1:0]   r_status;
    logic [TID_W-1:0]      r_sel_id;
    logic [LVL_PORT_W-1:0] r_sel_lvl;

    logic [LVL_W-1:0] pick_lvl;
    logic             pick_none;
    logic [LVL_W-1:0] sel;
    logic [LNK_W-1:0] head_sel;
    logic [LNK_W-1:0] tail_sel;
    logic             recycled;
    logic             full;
    logic [ENT_W-1:0] alloc_e;
    logic [EVT_W-1:0] cnt1;
    logic [15:0]      ins_ext;
    logic [LVL_W-1:0] ins_lvl;
    logic [LVL_W-1:0] demote_lvl;
    logic             deq_last;
    logic [15:0]      out_lvl_ext;

    logic             next_we;
    logic [ENT_W-1:0] next_waddr;
    logic [LNK_W-1:0] next_wdata;
    logic             next_re;
    logic [ENT_W-1:0] next_raddr;

    // lowest nonempty level
    always_comb begin
        pick_lvl  = '0;
        pick_none = 1'b1;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_head[i] != NIL) begin
                pick_lvl  = LVL_W'(i);
                pick_none = 1'b0;
            end
        end
    end

    assign sel      = i_cmd.pick ? pick_lvl : r_lvl;
    assign head_sel = r_head[sel];
    assign tail_sel = r_tail[sel];

    assign recycled = (r_free_head != NIL);
    assign full     = !recycled && (r_fresh == NIL);
    assign alloc_e  = recycled ? r_free_head[ENT_W-1:0] : r_fresh[ENT_W-1:0];

    assign cnt1 = r_evt + EVT_W'(1);

    assign ins_ext    = 16'(i_insert_level);
    assign ins_lvl    = (ins_ext > LVL_LAST_EXT) ? LVL_LAST : ins_ext[LVL_W-1:0];
    assign demote_lvl = (r_run_lvl == LVL_LAST) ? LVL_LAST : r_run_lvl + LVL_W'(1);

    assign deq_last = (LNK_W'(r_ent) == r_tail[r_lvl]);

    assign o_stat.full       = full;
    assign o_stat.req_needed = r_run_valid && (i_current_outcome == OUT_PREEMPT);
    assign o_stat.boost_hit  = (cnt1 >= r_interval);
    assign o_stat.boost_last = (r_lvl == LVL_LAST);
    assign o_stat.pick_none  = pick_none;

    // one write and one read port on the link memory
    always_comb begin
        next_we    = 1'b0;
        next_waddr = tail_sel[ENT_W-1:0];
        next_wdata = LNK_W'(alloc_e);
        if (i_cmd.alloc && !full && head_sel != NIL) begin
            next_we = 1'b1;
        end else if (i_cmd.boost && head_sel != NIL) begin
            next_we    = 1'b1;
            next_wdata = r_head[0];
        end else if (i_cmd.deq) begin
            next_we    = 1'b1;
            next_waddr = r_ent;
            next_wdata = r_free_head;
        end
    end

    assign next_re    = (i_cmd.alloc && recycled) || i_cmd.pick;
    assign next_raddr = i_cmd.pick ? head_sel[ENT_W-1:0] : r_free_head[ENT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            mem_next[next_waddr] <= next_wdata;
        end
        if (next_re) begin
            r_rd_next <= mem_next[next_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc && !full) begin
            mem_pay[alloc_e] <= {r_op_tid, r_lvl};
        end
        if (i_cmd.pick) begin
            r_rd_pay <= mem_pay[head_sel[ENT_W-1:0]];
        end
    end

    // operand and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ins) begin
            r_op_tid <= i_thread_id;
        end else if (i_cmd.ld_req) begin
            r_op_tid <= r_run_tid;
        end
        if (i_cmd.alloc || i_cmd.pick) begin
            r_ent <= i_cmd.pick ? head_sel[ENT_W-1:0] : alloc_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_evt       <= '0;
            r_interval  <= BOOST_INTERVAL_RST;
            r_run_tid   <= '0;
            r_run_lvl   <= '0;
            r_run_valid <= 1'b0;
            r_lvl       <= '0;
            r_recycled  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end

            if (i_cmd.ld_ins) begin
                r_lvl <= ins_lvl;
            end else if (i_cmd.ld_req) begin
                r_lvl <= demote_lvl;
            end

            if (i_cmd.alloc && !full) begin
                r_recycled <= recycled;
                if (!recycled) begin
                    r_fresh <= r_fresh + LNK_W'(1);
                end
                if (head_sel == NIL) begin
                    r_head[sel] <= LNK_W'(alloc_e);
                end
                r_tail[sel] <= LNK_W'(alloc_e);
            end

            if (i_cmd.pop && r_recycled) begin
                r_free_head <= r_rd_next;
            end

            if (i_cmd.count) begin
                r_run_valid <= 1'b0;
                r_evt       <= o_stat.boost_hit ? '0 : cnt1;
                r_lvl       <= LVL_W'(1);
            end

            if (i_cmd.boost) begin
                // level r_lvl goes in front of whatever level 0 now holds
                if (head_sel != NIL) begin
                    if (r_head[0] == NIL) begin
                        r_tail[0] <= tail_sel;
                    end
                    r_head[0]   <= head_sel;
                    r_head[sel] <= NIL;
                    r_tail[sel] <= NIL;
                end
                if (r_lvl != LVL_LAST) begin
                    r_lvl <= r_lvl + LVL_W'(1);
                end
            end

            if (i_cmd.pick) begin
                r_lvl <= pick_lvl;
            end

            if (i_cmd.deq) begin
                if (deq_last) begin
                    r_head[r_lvl] <= NIL;
                    r_tail[r_lvl] <= NIL;
                end else begin
                    r_head[r_lvl] <= r_rd_next;
                end
                r_free_head <= LNK_W'(r_ent);
                r_run_tid   <= r_rd_pay[PAY_W-1:LVL_W];
                r_run_lvl   <= r_rd_pay[LVL_W-1:0];
                r_run_valid <= 1'b1;
            end
        end
    end

    // result registers
    assign out_lvl_ext = 16'(r_rd_pay[LVL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.res_full || i_cmd.res_ok || i_cmd.res_none || i_cmd.deq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deq) begin
            r_status  <= ST_OK;
            r_sel_id  <= r_rd_pay[PAY_W-1:LVL_W];
            r_sel_lvl <= out_lvl_ext[LVL_PORT_W-1:0];
        end else if (i_cmd.res_full || i_cmd.res_ok || i_cmd.res_none) begin
            r_status  <= i_cmd.res_full ? ST_FULL : (i_cmd.res_none ? ST_EMPTY : ST_OK);
            r_sel_id  <= '0;
            r_sel_lvl <= '0;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_selected_id    = r_sel_id;
    assign o_selected_level = r_sel_lvl;

endmodule

/* rtl/core/multilevel_feedback_queue.sv */
// Top level of the multilevel feedback queue scheduler.
// Joins the controller (mfq_ctrl) and the datapath (mfq_dp); uses mfq_pkg.
`timescale 1ns / 1ps

// Usage
//   A command is taken on a rising edge with start high and busy low: opcode
//   0 inserts i_thread_id at i_insert_level, opcode 1 is a scheduling event
//   that uses i_current_outcome for the running thread.
//   Each command gives exactly one result, shown for one cycle with o_strobe
//   high: o_status, o_selected_id, o_selected_level. The receiver cannot
//   stall; the result must be taken in that cycle. The user must write
//   boost_interval (i_cfg_wr_en/i_cfg_wr_data) only while idle; not enforced.
// Sequence (accept to strobe, then busy is low again)
//   insert: allocate, pop, result; allocate gives it when the store is full.
//   schedule: count, a boost sweep on a boost event (one level per cycle),
//   pick, dequeue, result; nothing runnable ends at pick. A requeue of the
//   running thread comes first: allocate, pop, or only allocate if refused.
//   The linked entry store has one read and one write port per cycle, which
//   sets the step count of each sequence.
// Reset
//   Synchronous, active low: all levels empty, no thread running, event
//   count zero, boost_interval 100. No clearing pass; entries are handed out
//   from a fill count.
module multilevel_feedback_queue import mfq_pkg::*; #(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_opcode,
    input  logic [TID_W-1:0]      i_thread_id,
    input  logic [LVL_PORT_W-1:0] i_insert_level,
    input  logic [OUTCOME_W-1:0]  i_current_outcome,
    input  logic                  i_cfg_wr_en,
    input  logic [EVT_W-1:0]      i_cfg_wr_data,
    output logic                  o_strobe,
    output logic [STATUS_W-1:0]   o_status,
    output logic [TID_W-1:0]      o_selected_id,
    output logic [LVL_PORT_W-1:0] o_selected_level
);

    t_mfq_cmd  cmd;
    t_mfq_stat stat;

    mfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    mfq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_thread_id       (i_thread_id),
        .i_insert_level    (i_insert_level),
        .i_current_outcome (i_current_outcome),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_selected_id     (o_selected_id),
        .o_selected_level  (o_selected_level)
    );

endmodule
